@@ src/lldp_chk_pkg.sv @@
// shared types and constants of the lldp data unit tlv checker
package lldp_chk_pkg;

	// one input beat: a byte of the data unit
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [15:0] interface_number;
	} in_t;

	// one result beat: an id byte or a frame verdict
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  id_byte;
		logic        status;
		logic [7:0]  chassis_subtype;
		logic [7:0]  chassis_len;
		logic [7:0]  port_subtype;
		logic [7:0]  port_len;
		logic [15:0] hold_seconds;
		logic [15:0] source_interface;
		logic        run_last;
	} out_t;

	// configuration register contents
	typedef struct packed {
		logic [5:0] optional_type_mask;
		logic [7:0] chassis_id_max_len;
		logic [7:0] port_id_max_len;
	} cfg_t;

	// result kinds
	localparam logic [1:0] KIND_CHASSIS = 2'd0;
	localparam logic [1:0] KIND_PORT    = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// verdict codes
	localparam logic STATUS_GOOD = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	// register indexes
	localparam logic [1:0] REG_OPT_MASK   = 2'd0;
	localparam logic [1:0] REG_CHASSIS_MAX = 2'd1;
	localparam logic [1:0] REG_PORT_MAX   = 2'd2;

	// register reset values
	localparam logic [5:0] OPT_MASK_RESET = 6'd63;
	localparam logic [7:0] ID_MAX_RESET   = 8'd255;

	// tlv type codes
	localparam logic [6:0] TLV_END      = 7'd0;
	localparam logic [6:0] TLV_CHASSIS  = 7'd1;
	localparam logic [6:0] TLV_PORT     = 7'd2;
	localparam logic [6:0] TLV_TTL      = 7'd3;
	localparam logic [6:0] TLV_OPT_LOW  = 7'd4;
	localparam logic [6:0] TLV_OPT_HIGH = 7'd8;
	localparam logic [6:0] TLV_ORG      = 7'd127;

	// fixed ttl value length
	localparam logic [8:0] TTL_LEN = 9'd2;

	// parser phases
	typedef enum logic [12:0] {
		PH_CH_H1    = 13'b0000000000001,
		PH_CH_H2    = 13'b0000000000010,
		PH_CH_BODY  = 13'b0000000000100,
		PH_PT_H1    = 13'b0000000001000,
		PH_PT_H2    = 13'b0000000010000,
		PH_PT_BODY  = 13'b0000000100000,
		PH_TTL_H1   = 13'b0000001000000,
		PH_TTL_H2   = 13'b0000010000000,
		PH_TTL_BODY = 13'b0000100000000,
		PH_OPT_H1   = 13'b0001000000000,
		PH_OPT_H2   = 13'b0010000000000,
		PH_OPT_BODY = 13'b0100000000000,
		PH_DONE     = 13'b1000000000000
	} phase_t;

endpackage

@@ src/lldp_chk_regs.sv @@
// configuration registers behind the apb-style port
module lldp_chk_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output lldp_chk_pkg::cfg_t  cfg
);

	logic [1:0] reg_idx;
	logic       wr_en;
	logic [5:0] opt_mask_q;
	logic [7:0] ch_max_q;
	logic [7:0] pt_max_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_mask_q <= lldp_chk_pkg::OPT_MASK_RESET;
			ch_max_q   <= lldp_chk_pkg::ID_MAX_RESET;
			pt_max_q   <= lldp_chk_pkg::ID_MAX_RESET;
		end else if (wr_en) begin
			if (reg_idx == lldp_chk_pkg::REG_OPT_MASK) begin
				opt_mask_q <= pwdata[5:0];
			end
			if (reg_idx == lldp_chk_pkg::REG_CHASSIS_MAX) begin
				ch_max_q <= pwdata[7:0];
			end
			if (reg_idx == lldp_chk_pkg::REG_PORT_MAX) begin
				pt_max_q <= pwdata[7:0];
			end
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (reg_idx == lldp_chk_pkg::REG_OPT_MASK) begin
			prdata = {26'd0, opt_mask_q};
		end else if (reg_idx == lldp_chk_pkg::REG_CHASSIS_MAX) begin
			prdata = {24'd0, ch_max_q};
		end else if (reg_idx == lldp_chk_pkg::REG_PORT_MAX) begin
			prdata = {24'd0, pt_max_q};
		end
	end

	assign cfg.optional_type_mask = opt_mask_q;
	assign cfg.chassis_id_max_len = ch_max_q;
	assign cfg.port_id_max_len    = pt_max_q;

endmodule

@@ src/lldp_chk_parser.sv @@
// tlv parser state and per-byte result generation
module lldp_chk_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lldp_chk_pkg::in_t   item,
	input  lldp_chk_pkg::cfg_t  cfg,
	output logic [1:0]          res_count,
	output lldp_chk_pkg::out_t  res_a,
	output lldp_chk_pkg::out_t  res_b
);

	lldp_chk_pkg::phase_t phase_q, phase_d;
	logic [8:0]  cnt_q, cnt_d;
	logic [6:0]  type_q, type_d;
	logic [8:0]  len_q, len_d;
	logic        err_q, err_d;
	logic [7:0]  ch_sub_q, ch_sub_d;
	logic [7:0]  ch_len_q, ch_len_d;
	logic [7:0]  pt_sub_q, pt_sub_d;
	logic [7:0]  pt_len_q, pt_len_d;
	logic [15:0] ttl_q, ttl_d;

	logic [7:0]  b;
	logic [6:0]  hdr_type;
	logic [8:0]  len_full;
	logic [8:0]  len_m1;
	logic [8:0]  cnt_inc;
	logic [8:0]  ch_lim;
	logic [8:0]  pt_lim;
	logic        opt_ok;
	logic        id_emit;
	logic [1:0]  id_kind;
	logic        good;
	lldp_chk_pkg::out_t id_res;
	lldp_chk_pkg::out_t verdict_res;

	assign b        = item.data_byte;
	assign hdr_type = b[7:1];
	assign len_full = {len_q[8], b};
	assign len_m1   = len_q - 9'd1;
	assign cnt_inc  = cnt_q + 9'd1;
	assign ch_lim   = {1'b0, cfg.chassis_id_max_len} + 9'd1;
	assign pt_lim   = {1'b0, cfg.port_id_max_len} + 9'd1;

	// optional type permission from the mask
	always_comb begin
		opt_ok = 1'b0;
		if (hdr_type == lldp_chk_pkg::TLV_END) begin
			opt_ok = 1'b1;
		end else if (hdr_type >= lldp_chk_pkg::TLV_OPT_LOW
				&& hdr_type <= lldp_chk_pkg::TLV_OPT_HIGH) begin
			opt_ok = cfg.optional_type_mask[3'(hdr_type - lldp_chk_pkg::TLV_OPT_LOW)];
		end else if (hdr_type == lldp_chk_pkg::TLV_ORG) begin
			opt_ok = cfg.optional_type_mask[5];
		end
	end

	// next state for one byte
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		type_d   = type_q;
		len_d    = len_q;
		err_d    = err_q;
		ch_sub_d = ch_sub_q;
		ch_len_d = ch_len_q;
		pt_sub_d = pt_sub_q;
		pt_len_d = pt_len_q;
		ttl_d    = ttl_q;
		id_emit  = 1'b0;
		id_kind  = lldp_chk_pkg::KIND_CHASSIS;
		good     = 1'b0;
		if (!err_q) begin
			unique case (phase_q)
				lldp_chk_pkg::PH_CH_H1, lldp_chk_pkg::PH_PT_H1,
				lldp_chk_pkg::PH_TTL_H1: begin
					type_d = hdr_type;
					len_d  = {b[0], 8'h00};
					cnt_d  = '0;
					if (phase_q == lldp_chk_pkg::PH_CH_H1) begin
						if (hdr_type != lldp_chk_pkg::TLV_CHASSIS) err_d = 1'b1;
						else phase_d = lldp_chk_pkg::PH_CH_H2;
					end else if (phase_q == lldp_chk_pkg::PH_PT_H1) begin
						if (hdr_type != lldp_chk_pkg::TLV_PORT) err_d = 1'b1;
						else phase_d = lldp_chk_pkg::PH_PT_H2;
					end else begin
						if (hdr_type != lldp_chk_pkg::TLV_TTL) err_d = 1'b1;
						else phase_d = lldp_chk_pkg::PH_TTL_H2;
					end
				end
				lldp_chk_pkg::PH_CH_H2: begin
					len_d = len_full;
					if (len_full < 9'd2 || len_full > ch_lim) err_d = 1'b1;
					else phase_d = lldp_chk_pkg::PH_CH_BODY;
				end
				lldp_chk_pkg::PH_PT_H2: begin
					len_d = len_full;
					if (len_full < 9'd2 || len_full > pt_lim) err_d = 1'b1;
					else phase_d = lldp_chk_pkg::PH_PT_BODY;
				end
				lldp_chk_pkg::PH_TTL_H2: begin
					len_d = len_full;
					if (len_full != lldp_chk_pkg::TTL_LEN) err_d = 1'b1;
					else phase_d = lldp_chk_pkg::PH_TTL_BODY;
				end
				lldp_chk_pkg::PH_CH_BODY, lldp_chk_pkg::PH_PT_BODY: begin
					// first body byte is the subtype, the rest are id bytes
					if (cnt_q == 9'd0) begin
						if (phase_q == lldp_chk_pkg::PH_CH_BODY) begin
							ch_sub_d = b;
							ch_len_d = len_m1[7:0];
						end else begin
							pt_sub_d = b;
							pt_len_d = len_m1[7:0];
						end
					end else begin
						id_emit = 1'b1;
						id_kind = (phase_q == lldp_chk_pkg::PH_CH_BODY)
							? lldp_chk_pkg::KIND_CHASSIS : lldp_chk_pkg::KIND_PORT;
					end
					if (cnt_inc >= len_q) begin
						phase_d = (phase_q == lldp_chk_pkg::PH_CH_BODY)
							? lldp_chk_pkg::PH_PT_H1 : lldp_chk_pkg::PH_TTL_H1;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				lldp_chk_pkg::PH_TTL_BODY: begin
					// ttl is big-endian
					if (cnt_q == 9'd0) ttl_d = {b, 8'h00};
					else ttl_d = {ttl_q[15:8], b};
					if (cnt_inc >= lldp_chk_pkg::TTL_LEN) begin
						phase_d = lldp_chk_pkg::PH_OPT_H1;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				lldp_chk_pkg::PH_OPT_H1: begin
					type_d = hdr_type;
					len_d  = {b[0], 8'h00};
					cnt_d  = '0;
					if (opt_ok) phase_d = lldp_chk_pkg::PH_OPT_H2;
					else err_d = 1'b1;
				end
				lldp_chk_pkg::PH_OPT_H2: begin
					len_d = len_full;
					if (type_q == lldp_chk_pkg::TLV_END) begin
						if (len_full != 9'd0) err_d = 1'b1;
						else phase_d = lldp_chk_pkg::PH_DONE;
					end else begin
						phase_d = (len_full == 9'd0)
							? lldp_chk_pkg::PH_OPT_H1 : lldp_chk_pkg::PH_OPT_BODY;
					end
				end
				lldp_chk_pkg::PH_OPT_BODY: begin
					if (cnt_inc >= len_q) begin
						phase_d = lldp_chk_pkg::PH_OPT_H1;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				lldp_chk_pkg::PH_DONE: begin
					// trailing bytes after the end tlv are ignored
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
		// frame end: verdict, then back to the first header
		if (item.frame_end) begin
			good    = !err_d && (phase_d == lldp_chk_pkg::PH_DONE);
			phase_d = lldp_chk_pkg::PH_CH_H1;
			cnt_d   = '0;
			type_d  = '0;
			len_d   = '0;
			err_d   = 1'b0;
		end
	end

	// id byte result
	always_comb begin
		id_res                  = '0;
		id_res.result_kind      = id_kind;
		id_res.id_byte          = b;
		id_res.status           = lldp_chk_pkg::STATUS_GOOD;
		id_res.source_interface = item.interface_number;
		id_res.run_last         = !item.frame_end;
	end

	// verdict result, held values only when good
	always_comb begin
		verdict_res                  = '0;
		verdict_res.result_kind      = lldp_chk_pkg::KIND_VERDICT;
		verdict_res.status           = good ? lldp_chk_pkg::STATUS_GOOD
		                                    : lldp_chk_pkg::STATUS_BAD;
		verdict_res.source_interface = item.interface_number;
		verdict_res.run_last         = 1'b1;
		if (good) begin
			verdict_res.chassis_subtype = ch_sub_d;
			verdict_res.chassis_len     = ch_len_d;
			verdict_res.port_subtype    = pt_sub_d;
			verdict_res.port_len        = pt_len_d;
			verdict_res.hold_seconds    = ttl_d;
		end
	end

	assign res_a     = id_emit ? id_res : verdict_res;
	assign res_b     = verdict_res;
	assign res_count = {1'b0, id_emit} + {1'b0, item.frame_end};

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lldp_chk_pkg::PH_CH_H1;
			cnt_q    <= '0;
			type_q   <= '0;
			len_q    <= '0;
			err_q    <= 1'b0;
			ch_sub_q <= '0;
			ch_len_q <= '0;
			pt_sub_q <= '0;
			pt_len_q <= '0;
			ttl_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			type_q   <= type_d;
			len_q    <= len_d;
			err_q    <= err_d;
			ch_sub_q <= ch_sub_d;
			ch_len_q <= ch_len_d;
			pt_sub_q <= pt_sub_d;
			pt_len_q <= pt_len_d;
			ttl_q    <= ttl_d;
		end
	end

	// a frame end always leaves the parser at the first header with no error
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.frame_end |=> phase_q == lldp_chk_pkg::PH_CH_H1 && !err_q)
		else $error("parser did not restart after frame end");

endmodule

@@ src/lldp_chk_outq.sv @@
// result queue taking up to two beats per cycle
module lldp_chk_outq #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_count,
	input  lldp_chk_pkg::out_t  push_a,
	input  lldp_chk_pkg::out_t  push_b,
	output logic                has_room,
	output logic                out_valid,
	input  logic                out_ready,
	output lldp_chk_pkg::out_t  out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	lldp_chk_pkg::out_t entry_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wr1;
	logic [PW-1:0] wr2;
	logic          pop;

	assign wr1       = ptr_next(wr_q);
	assign wr2       = ptr_next(wr1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_q];
	// two free slots once this cycle's pop is counted
	assign has_room  = (cnt_q <= CW'(DEPTH - 2)) || (pop && cnt_q <= CW'(DEPTH - 1));

	// entry writes
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_q] <= push_a;
		end
		if (push_count == 2'd2) begin
			entry_q[wr1] <= push_b;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_count == 2'd1) wr_q <= wr1;
			else if (push_count == 2'd2) wr_q <= wr2;
			if (pop) rd_q <= ptr_next(rd_q);
			cnt_q <= cnt_q + CW'(push_count) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_count != 2'd0 |-> has_room)
		else $error("push into result queue without room");

endmodule

@@ src/lldp_pdu_tlv_checker.sv @@
// Checks the TLV sequence of received LLDP data units, one byte per beat.
// A byte is taken into an input register and parsed from there, and its
// results (an ID byte, a frame verdict, or both) enter a result queue of
// OUT_DEPTH entries whose head drives the output. The block sustains one
// byte per cycle while the consumer keeps up and the queue has room; the
// input register stalls only when the result queue has fewer than two free
// entries, counting this cycle's pop, which can happen after an ID byte on
// a frame's last byte or while the output is held off.
module lldp_pdu_tlv_checker #(
	parameter int OUT_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	// input bytes
	input  logic                in_valid,
	output logic                in_ready,
	input  lldp_chk_pkg::in_t   in_data,
	// results
	output logic                out_valid,
	input  logic                out_ready,
	output lldp_chk_pkg::out_t  out_data,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	lldp_chk_pkg::cfg_t cfg;
	lldp_chk_pkg::in_t  item_s1;
	logic               valid_s1;
	logic               advance;
	logic               has_room;
	logic [1:0]         res_count;
	logic [1:0]         push_count;
	lldp_chk_pkg::out_t res_a;
	lldp_chk_pkg::out_t res_b;

	lldp_chk_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	assign advance  = valid_s1 && has_room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lldp_chk_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_count (res_count),
		.res_a     (res_a),
		.res_b     (res_b)
	);

	assign push_count = advance ? res_count : 2'd0;

	lldp_chk_outq #(
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push_a     (res_a),
		.push_b     (res_b),
		.has_room   (has_room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// an accepted beat is held in the input register next cycle
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat lost at input register");

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the lldp data unit tlv checker, random frames against a byte parser
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	lldp_chk_pkg::in_t   in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	lldp_chk_pkg::out_t  out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	lldp_pdu_tlv_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	// bench bookkeeping
	lldp_chk_pkg::in_t   pending_bytes[$];
	lldp_chk_pkg::out_t  awaited_results[$];
	logic [7:0]  frame_buf[$];
	int          mismatches = 0;
	int          send_gap = 0;
	int          bytes_sent = 0;
	int          recv_hold = 0;
	int          results_seen = 0;
	int          bytes_seen = 0;
	bit          long_hold_done = 1'b0;
	bit          calm = 1'b0;

	// register values used to shape the generated frames
	logic [5:0]  gen_opt_mask = lldp_chk_pkg::OPT_MASK_RESET;
	logic [7:0]  gen_ch_max = lldp_chk_pkg::ID_MAX_RESET;
	logic [7:0]  gen_pt_max = lldp_chk_pkg::ID_MAX_RESET;

	// parser model state and its copy of the registers
	lldp_chk_pkg::phase_t parse_phase = lldp_chk_pkg::PH_CH_H1;
	logic [8:0]  tlv_count = '0;
	logic [8:0]  tlv_len = '0;
	logic [6:0]  tlv_kind = '0;
	logic        bad_tlv = 1'b0;
	logic [7:0]  held_ch_sub = '0;
	logic [7:0]  held_ch_len = '0;
	logic [7:0]  held_pt_sub = '0;
	logic [7:0]  held_pt_len = '0;
	logic [15:0] held_ttl = '0;
	logic [5:0]  cfg_opt_mask = lldp_chk_pkg::OPT_MASK_RESET;
	logic [7:0]  cfg_ch_max = lldp_chk_pkg::ID_MAX_RESET;
	logic [7:0]  cfg_pt_max = lldp_chk_pkg::ID_MAX_RESET;

	// optional tlv admitted by the type mask
	function automatic logic option_enabled(input logic [6:0] kind);
		if (kind >= lldp_chk_pkg::TLV_OPT_LOW && kind <= lldp_chk_pkg::TLV_OPT_HIGH)
			return cfg_opt_mask[kind - lldp_chk_pkg::TLV_OPT_LOW];
		return (kind == lldp_chk_pkg::TLV_ORG) && cfg_opt_mask[5];
	endfunction

	function automatic lldp_chk_pkg::out_t make_result(input logic [1:0] kind,
			input logic [7:0] idb, input logic st, input logic with_held,
			input logic [15:0] intf);
		lldp_chk_pkg::out_t r;
		r = '0;
		r.result_kind = kind;
		r.id_byte = idb;
		r.status = st;
		if (with_held) begin
			r.chassis_subtype = held_ch_sub;
			r.chassis_len = held_ch_len;
			r.port_subtype = held_pt_sub;
			r.port_len = held_pt_len;
			r.hold_seconds = held_ttl;
		end
		r.source_interface = intf;
		return r;
	endfunction

	// first header byte of a mandatory tlv
	task automatic take_header(input logic [7:0] b, input logic [6:0] want,
			input lldp_chk_pkg::phase_t nxt);
		tlv_kind = b[7:1];
		tlv_len = {b[0], 8'h00};
		tlv_count = '0;
		if (tlv_kind != want)
			bad_tlv = 1'b1;
		else
			parse_phase = nxt;
	endtask

	// id tlv must carry a subtype and 1..max id bytes
	task automatic check_id_len(input logic [7:0] maxlen, input lldp_chk_pkg::phase_t nxt);
		if (int'(tlv_len) < 2 || int'(tlv_len) > int'(maxlen) + 1)
			bad_tlv = 1'b1;
		else
			parse_phase = nxt;
	endtask

	// advance the parser model by one byte and queue the results it causes
	task automatic parse_lldp_byte(input lldp_chk_pkg::in_t beat);
		lldp_chk_pkg::out_t res[$];
		logic [7:0] b;
		logic       good;
		logic       in_chassis;
		b = beat.data_byte;
		if (!bad_tlv) begin
			case (parse_phase)
				lldp_chk_pkg::PH_CH_H1:
					take_header(b, lldp_chk_pkg::TLV_CHASSIS, lldp_chk_pkg::PH_CH_H2);
				lldp_chk_pkg::PH_PT_H1:
					take_header(b, lldp_chk_pkg::TLV_PORT, lldp_chk_pkg::PH_PT_H2);
				lldp_chk_pkg::PH_TTL_H1:
					take_header(b, lldp_chk_pkg::TLV_TTL, lldp_chk_pkg::PH_TTL_H2);
				lldp_chk_pkg::PH_CH_H2: begin
					tlv_len = tlv_len | b;
					check_id_len(cfg_ch_max, lldp_chk_pkg::PH_CH_BODY);
				end
				lldp_chk_pkg::PH_PT_H2: begin
					tlv_len = tlv_len | b;
					check_id_len(cfg_pt_max, lldp_chk_pkg::PH_PT_BODY);
				end
				lldp_chk_pkg::PH_TTL_H2: begin
					tlv_len = tlv_len | b;
					if (tlv_len != lldp_chk_pkg::TTL_LEN)
						bad_tlv = 1'b1;
					else
						parse_phase = lldp_chk_pkg::PH_TTL_BODY;
				end
				lldp_chk_pkg::PH_CH_BODY, lldp_chk_pkg::PH_PT_BODY: begin
					in_chassis = (parse_phase == lldp_chk_pkg::PH_CH_BODY);
					// first body byte is the subtype, the rest are id bytes
					if (tlv_count == 0) begin
						if (in_chassis) begin
							held_ch_sub = b;
							held_ch_len = 8'(tlv_len - 9'd1);
						end else begin
							held_pt_sub = b;
							held_pt_len = 8'(tlv_len - 9'd1);
						end
					end else begin
						res.push_back(make_result(in_chassis ? lldp_chk_pkg::KIND_CHASSIS
							: lldp_chk_pkg::KIND_PORT, b, lldp_chk_pkg::STATUS_GOOD, 1'b0,
							beat.interface_number));
					end
					tlv_count = tlv_count + 9'd1;
					if (tlv_count >= tlv_len) begin
						parse_phase = in_chassis ? lldp_chk_pkg::PH_PT_H1
							: lldp_chk_pkg::PH_TTL_H1;
						tlv_count = '0;
					end
				end
				lldp_chk_pkg::PH_TTL_BODY: begin
					if (tlv_count == 0)
						held_ttl = {b, 8'h00};
					else
						held_ttl = {held_ttl[15:8], b};
					tlv_count = tlv_count + 9'd1;
					if (tlv_count >= lldp_chk_pkg::TTL_LEN) begin
						parse_phase = lldp_chk_pkg::PH_OPT_H1;
						tlv_count = '0;
					end
				end
				lldp_chk_pkg::PH_OPT_H1: begin
					tlv_kind = b[7:1];
					tlv_len = {b[0], 8'h00};
					tlv_count = '0;
					if (tlv_kind == lldp_chk_pkg::TLV_END || option_enabled(tlv_kind))
						parse_phase = lldp_chk_pkg::PH_OPT_H2;
					else
						bad_tlv = 1'b1;
				end
				lldp_chk_pkg::PH_OPT_H2: begin
					tlv_len = tlv_len | b;
					if (tlv_kind == lldp_chk_pkg::TLV_END) begin
						if (tlv_len != 0)
							bad_tlv = 1'b1;
						else
							parse_phase = lldp_chk_pkg::PH_DONE;
					end else begin
						parse_phase = (tlv_len == 0) ? lldp_chk_pkg::PH_OPT_H1
							: lldp_chk_pkg::PH_OPT_BODY;
					end
				end
				lldp_chk_pkg::PH_OPT_BODY: begin
					tlv_count = tlv_count + 9'd1;
					if (tlv_count >= tlv_len) begin
						parse_phase = lldp_chk_pkg::PH_OPT_H1;
						tlv_count = '0;
					end
				end
				lldp_chk_pkg::PH_DONE: ;
				default: bad_tlv = 1'b1;
			endcase
		end
		// verdict on the frame's last byte, then back to the opening phase
		if (beat.frame_end) begin
			good = !bad_tlv && parse_phase == lldp_chk_pkg::PH_DONE;
			res.push_back(make_result(lldp_chk_pkg::KIND_VERDICT, 8'h00,
				good ? lldp_chk_pkg::STATUS_GOOD : lldp_chk_pkg::STATUS_BAD,
				good, beat.interface_number));
			parse_phase = lldp_chk_pkg::PH_CH_H1;
			tlv_count = '0;
			tlv_kind = '0;
			tlv_len = '0;
			bad_tlv = 1'b0;
		end
		if (res.size() > 0)
			res[res.size() - 1].run_last = 1'b1;
		foreach (res[i])
			awaited_results.push_back(res[i]);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// input side: offers queued bytes, with bursts of idling
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_bytes.size() > 0) begin
				in_data <= pending_bytes.pop_front();
				in_valid <= 1'b1;
				bytes_sent++;
				if (!calm && (bytes_sent % 192) >= 64 && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: checks results, tracks register writes, predicts, drives ready
	always @(posedge clk) begin
		lldp_chk_pkg::out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					lldp_chk_pkg::REG_OPT_MASK: cfg_opt_mask = pwdata[5:0];
					lldp_chk_pkg::REG_CHASSIS_MAX: cfg_ch_max = pwdata[7:0];
					lldp_chk_pkg::REG_PORT_MAX: cfg_pt_max = pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result with nothing expected, got %0h", $time, out_data);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("result_kind", want.result_kind, out_data.result_kind);
					check_field("id_byte", want.id_byte, out_data.id_byte);
					check_field("status", want.status, out_data.status);
					check_field("chassis_subtype", want.chassis_subtype, out_data.chassis_subtype);
					check_field("chassis_len", want.chassis_len, out_data.chassis_len);
					check_field("port_subtype", want.port_subtype, out_data.port_subtype);
					check_field("port_len", want.port_len, out_data.port_len);
					check_field("hold_seconds", want.hold_seconds, out_data.hold_seconds);
					check_field("source_interface", want.source_interface,
						out_data.source_interface);
					check_field("run_last", want.run_last, out_data.run_last);
				end
			end
			if (in_valid && in_ready) begin
				parse_lldp_byte(in_data);
				bytes_seen++;
			end
			// one long hold-off mid run so the block backs up and stalls its input
			if (bytes_seen == 600 && !long_hold_done) begin
				recv_hold = 300;
				long_hold_done = 1'b1;
			end
			if (recv_hold > 0) begin
				out_ready <= 1'b0;
				recv_hold--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && (results_seen % 160) >= 40 && $urandom_range(0, 4) == 0)
					recv_hold = $urandom_range(1, 9);
			end
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [5:0] mask, input logic [7:0] ch_max,
			input logic [7:0] pt_max);
		gen_opt_mask = mask;
		gen_ch_max = ch_max;
		gen_pt_max = pt_max;
		apb_write(lldp_chk_pkg::REG_OPT_MASK, {26'd0, mask});
		apb_write(lldp_chk_pkg::REG_CHASSIS_MAX, {24'd0, ch_max});
		apb_write(lldp_chk_pkg::REG_PORT_MAX, {24'd0, pt_max});
	endtask

	// all bytes taken and all results in, plus room for bytes still in flight
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_tlv_header(input logic [6:0] kind, input logic [8:0] len);
		frame_buf.push_back({kind, len[8]});
		frame_buf.push_back(len[7:0]);
	endtask

	// mostly short ids, now and then the full range or one past the maximum
	function automatic int pick_id_len(input logic [7:0] maxlen);
		if (maxlen == 0)
			return $urandom_range(1, 4);
		if ($urandom_range(0, 19) == 0)
			return int'(maxlen) + 1;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(1, maxlen);
		return $urandom_range(1, (maxlen < 8) ? maxlen : 8);
	endfunction

	task automatic add_id_tlv(input logic [6:0] kind, input logic [7:0] maxlen);
		int n;
		n = pick_id_len(maxlen);
		add_tlv_header(kind, 9'(n + 1));
		repeat (n + 1) frame_buf.push_back(8'($urandom));
	endtask

	// data unit under the current settings, optionally with a stray tlv; ids are now and then one past the maximum
	task automatic build_frame(input bit odd_option);
		logic [6:0] allowed[$];
		int         n;
		int         len;
		frame_buf.delete();
		add_id_tlv(lldp_chk_pkg::TLV_CHASSIS, gen_ch_max);
		add_id_tlv(lldp_chk_pkg::TLV_PORT, gen_pt_max);
		add_tlv_header(lldp_chk_pkg::TLV_TTL, lldp_chk_pkg::TTL_LEN);
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'($urandom));
		for (int i = 0; i < 6; i++)
			if (gen_opt_mask[i])
				allowed.push_back((i == 5) ? lldp_chk_pkg::TLV_ORG
					: 7'(lldp_chk_pkg::TLV_OPT_LOW + i));
		n = (allowed.size() > 0) ? $urandom_range(0, 3) : 0;
		repeat (n) begin
			len = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
			add_tlv_header(allowed[$urandom_range(0, allowed.size() - 1)], 9'(len));
			repeat (len) frame_buf.push_back(8'($urandom));
		end
		if (odd_option) begin
			len = $urandom_range(0, 3);
			add_tlv_header(7'($urandom_range(0, 127)), 9'(len));
			repeat (len) frame_buf.push_back(8'($urandom));
		end
		add_tlv_header(lldp_chk_pkg::TLV_END, 9'd0);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
	endtask

	task automatic emit_frame(input logic [15:0] intf);
		foreach (frame_buf[i])
			pending_bytes.push_back('{data_byte: frame_buf[i],
				frame_end: (i == frame_buf.size() - 1), interface_number: intf});
	endtask

	// mix of good frames, cut or corrupted frames and plain noise
	task automatic fill_phase(input int target);
		int made;
		int pick;
		int cut;
		made = 0;
		while (made < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				frame_buf.delete();
				repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
			end else begin
				build_frame(pick == 2);
				if (pick >= 3 && pick <= 5) begin
					if ($urandom_range(0, 1) == 0) begin
						cut = $urandom_range(0, frame_buf.size() - 2);
						frame_buf = frame_buf[0:cut];
					end else begin
						frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
					end
				end
			end
			emit_frame(16'($urandom));
			made += frame_buf.size();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// minimal good unit with a trailing byte after the end tlv
		frame_buf = '{8'h02, 8'h02, 8'hFF, 8'h00, 8'h04, 8'h02, 8'h00, 8'hFF,
			8'h06, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h5A};
		emit_frame(16'hFFFF);
		// frame ends on a chassis id byte: id beat then verdict
		frame_buf = '{8'h02, 8'h02, 8'hAA, 8'h55};
		emit_frame(16'h0000);
		// chassis id length of zero, later byte ignored
		frame_buf = '{8'h02, 8'h00, 8'h33};
		emit_frame(16'hA5C3);
		// wrong type in chassis position
		frame_buf = '{8'hFF};
		emit_frame(16'h5A3C);
		fill_phase(400);
		wait_drained();

		apply_settings(6'd0, 8'd1, 8'd1);
		fill_phase(300);
		wait_drained();

		apply_settings(6'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
		fill_phase(400);
		wait_drained();

		// zero maximum: every unit must be bad
		apply_settings(lldp_chk_pkg::OPT_MASK_RESET, 8'd0, lldp_chk_pkg::ID_MAX_RESET);
		fill_phase(100);
		wait_drained();

		// closing stretch at full rate, no idling on either side
		apply_settings(lldp_chk_pkg::OPT_MASK_RESET, lldp_chk_pkg::ID_MAX_RESET,
			lldp_chk_pkg::ID_MAX_RESET);
		calm = 1'b1;
		fill_phase(400);
		wait_drained();
		repeat (12) @(negedge clk);

		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
